/* src/sfcd_pkg.sv */
`default_nettype none

package sfcd_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  MAG_MASK   = 8'h7F;
  localparam logic [7:0]  SIGN_BIT   = 8'h80;
  localparam int          FRAME_LEN  = 8;
  localparam int          QUEUE_DEPTH = 2;

  // Byte positions within a reply frame
  typedef enum logic [2:0] {
    POS_ADDR     = 3'd0,
    POS_FUNC     = 3'd1,
    POS_HUM_HI   = 3'd2,
    POS_HUM_LO   = 3'd3,
    POS_TEMP_HI  = 3'd4,
    POS_TEMP_LO  = 3'd5,
    POS_CRC_LO   = 3'd6,
    POS_CRC_HI   = 3'd7
  } byte_pos_t;

  // One checked frame, handed from the front end to the back end
  typedef struct packed {
    logic        crc_ok;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Reflected CRC-16 update over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Sign-magnitude word to two's complement
  function automatic logic [15:0] sm_to_twos(input logic [15:0] raw);
    logic [15:0] mag;
    mag = {raw[15:8] & MAG_MASK, raw[7:0]};
    if ((raw[15:8] & SIGN_BIT) != 8'h00) begin
      return 16'h0000 - mag;
    end
    return mag;
  endfunction

endpackage

`default_nettype wire

/* src/sfcd_front.sv */
`default_nettype none

module sfcd_front
  import sfcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic [7:0]  in_data_byte,
  output logic             in_full,
  input  wire q_status_t   q_stat,
  output logic             rec_push,
  output frame_rec_t       rec
);

  byte_pos_t   pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] hum_raw_r, hum_raw_nxt;
  logic [15:0] temp_raw_r, temp_raw_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        accept;

  // Stall only on the closing byte, when the frame queue has no room
  assign in_full = (pos_r == POS_CRC_HI) && q_stat.full;
  assign accept  = in_push && !in_full;

  always_comb begin
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    hum_raw_nxt  = hum_raw_r;
    temp_raw_nxt = temp_raw_r;
    crc_lo_nxt   = crc_lo_r;
    rec_push     = 1'b0;
    rec.crc_ok   = ({in_data_byte, crc_lo_r} == crc_r);
    rec.temp_raw = temp_raw_r;
    rec.hum_raw  = hum_raw_r;
    if (accept) begin
      pos_nxt = byte_pos_t'(pos_r + 3'd1);
      if (pos_r != POS_CRC_LO && pos_r != POS_CRC_HI) begin
        crc_nxt = crc_byte(crc_r, in_data_byte);
      end
      unique case (pos_r)
        POS_HUM_HI:  hum_raw_nxt  = {in_data_byte, hum_raw_r[7:0]};
        POS_HUM_LO:  hum_raw_nxt  = {hum_raw_r[15:8], in_data_byte};
        POS_TEMP_HI: temp_raw_nxt = {in_data_byte, temp_raw_r[7:0]};
        POS_TEMP_LO: temp_raw_nxt = {temp_raw_r[15:8], in_data_byte};
        POS_CRC_LO:  crc_lo_nxt   = in_data_byte;
        POS_CRC_HI: begin
          rec_push = 1'b1;
          pos_nxt  = POS_ADDR;
          crc_nxt  = CRC_INIT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_ADDR;
      crc_r      <= CRC_INIT;
      hum_raw_r  <= '0;
      temp_raw_r <= '0;
      crc_lo_r   <= '0;
    end else begin
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      hum_raw_r  <= hum_raw_nxt;
      temp_raw_r <= temp_raw_nxt;
      crc_lo_r   <= crc_lo_nxt;
    end
  end

`ifndef SYNTHESIS
  a_frame_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos_r == POS_CRC_HI) |=> (pos_r == POS_ADDR && crc_r == CRC_INIT))
    else $error("front end did not rearm after closing byte");
  a_push_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push |-> (pos_r == POS_CRC_HI && !q_stat.full))
    else $error("frame record pushed off the closing byte or into a full queue");
`endif

endmodule

`default_nettype wire

/* src/sfcd_queue.sv */
`default_nettype none

module sfcd_queue
  import sfcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire frame_rec_t wdata,
  input  wire logic       pop,
  output frame_rec_t      rdata,
  output q_status_t       stat
);

  frame_rec_t mem [QUEUE_DEPTH];
  logic [$clog2(QUEUE_DEPTH)-1:0] wr_ptr_r, rd_ptr_r;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign stat.full  = (count_r == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("frame queue count out of range");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("push into full frame queue");
`endif

endmodule

`default_nettype wire

/* src/sfcd_back.sv */
`default_nettype none

module sfcd_back
  import sfcd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire q_status_t         q_stat,
  input  wire frame_rec_t        rec,
  output logic                   q_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic signed [15:0]     out_temperature_tenths,
  output logic        [15:0]     out_humidity_tenths,
  output logic                   out_crc_ok
);

  logic        out_valid_r;
  logic [15:0] held_temp_r, held_temp_nxt;
  logic [15:0] held_hum_r, held_hum_nxt;
  logic [15:0] out_temp_r;
  logic [15:0] out_hum_r;
  logic        out_ok_r;

  // Load the output register when it is free or being drained this cycle
  assign q_pop     = !q_stat.empty && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;

  always_comb begin
    held_temp_nxt = held_temp_r;
    held_hum_nxt  = held_hum_r;
    if (q_pop && rec.crc_ok) begin
      held_temp_nxt = sm_to_twos(rec.temp_raw);
      held_hum_nxt  = rec.hum_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      held_temp_r <= '0;
      held_hum_r  <= '0;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      held_temp_r <= held_temp_nxt;
      held_hum_r  <= held_hum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_temp_r <= held_temp_nxt;
      out_hum_r  <= held_hum_nxt;
      out_ok_r   <= rec.crc_ok;
    end
  end

  assign out_temperature_tenths = $signed(out_temp_r);
  assign out_humidity_tenths    = out_hum_r;
  assign out_crc_ok             = out_ok_r;

`ifndef SYNTHESIS
  a_fail_keeps_held: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !rec.crc_ok) |=> (held_temp_r == $past(held_temp_r)
                               && held_hum_r == $past(held_hum_r)))
    else $error("held values changed on a failed frame");
`endif

endmodule

`default_nettype wire

/* src/sensor_frame_crc_decoder.sv */
// Sensor reply-frame checker and decoder.
// Input channel (push/full): one frame byte per transfer on in_data_byte, frames
// of eight bytes back to back with no resync; every eighth byte closes a frame.
// A CRC-16 (reflected, poly 0xA001, seed 0xFFFF) runs over bytes 0..5 and is
// compared with bytes 6 (low) and 7 (high).
// Result channel (empty/pop): one result per frame, holding temperature in tenths
// (two's complement, from the sign-magnitude word in bytes 4..5), humidity in
// tenths (bytes 2..3) and crc_ok. On a CRC failure the last good values repeat
// with crc_ok low (zeros if no frame has passed since reset).
// Throughput: one byte per cycle while in_full is low. Result path: the frame
// queue is written when the closing byte transfers, and the back end output
// register loads from the queue once it is free or being drained by out_pop.
// Stalls: a two-entry frame queue sits between front and back end, so the input
// keeps taking bytes while a result waits; full rises only on a closing byte when
// that queue is also full.
// Reset (rst_n low, synchronous): frame position back to byte 0, CRC reseeded,
// held values cleared, queue and output register emptied.
`default_nettype none

module sensor_frame_crc_decoder
  import sfcd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  input  wire logic [7:0]    in_data_byte,
  output logic               in_full,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic signed [15:0] out_temperature_tenths,
  output logic        [15:0] out_humidity_tenths,
  output logic               out_crc_ok
);

  q_status_t  q_stat;
  frame_rec_t rec_in;
  frame_rec_t rec_out;
  logic       rec_push;
  logic       rec_pop;

  // Front end: track byte position, run the CRC, capture the raw words
  sfcd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_full      (in_full),
    .q_stat       (q_stat),
    .rec_push     (rec_push),
    .rec          (rec_in)
  );

  // Short queue of checked frames decouples the two ends
  sfcd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .wdata (rec_in),
    .pop   (rec_pop),
    .rdata (rec_out),
    .stat  (q_stat)
  );

  // Back end: update held values, convert sign, drive the result register
  sfcd_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_stat                 (q_stat),
    .rec                    (rec_out),
    .q_pop                  (rec_pop),
    .out_empty              (out_empty),
    .out_pop                (out_pop),
    .out_temperature_tenths (out_temperature_tenths),
    .out_humidity_tenths    (out_humidity_tenths),
    .out_crc_ok             (out_crc_ok)
  );

endmodule

`default_nettype wire
